// ----- sv/ps2mc_pkg.sv -----
// Shared types and constants for the PS/2 mouse packet cursor block.
package ps2mc_pkg;

    localparam int SizeBits = 14;
    localparam int DeltaBits = 9;
    localparam int ButtonBits = 3;

    localparam logic [SizeBits-1:0] DefaultLimitX = 14'd1023;
    localparam logic [SizeBits-1:0] DefaultLimitY = 14'd767;
    localparam logic [SizeBits-1:0] ResetPosX = 14'd512;
    localparam logic [SizeBits-1:0] ResetPosY = 14'd384;

    localparam logic [7:0] SyncMask = 8'h08;
    localparam logic [7:0] OverflowMask = 8'hC0;

    // Configuration register indexes.
    localparam logic REG_SCREEN_WIDTH = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        EV_STORED    = 2'd0,
        EV_APPLIED   = 2'd1,
        EV_SYNC_DROP = 2'd2,
        EV_OVF_DROP  = 2'd3
    } event_t;

    typedef struct packed {
        event_t                  ev;
        logic                    apply;
        logic [DeltaBits-1:0]    dx;
        logic [DeltaBits-1:0]    dy;
        logic [ButtonBits-1:0]   buttons;
    } step_t;

endpackage

// ----- sv/ps2mc_frame.sv -----
// Packet framing: tracks the byte position and holds the flag and X bytes.
module ps2mc_frame (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           rx_byte,
    output ps2mc_pkg::step_t     result
);

    typedef enum logic [2:0] {
        POS_FLAG   = 3'b001,
        POS_XDELTA = 3'b010,
        POS_YDELTA = 3'b100
    } pos_t;

    pos_t       pos_reg, pos_next;
    logic [7:0] flag_reg, flag_next;
    logic [7:0] xdelta_reg, xdelta_next;

    always_comb
    begin
        pos_next = pos_reg;
        flag_next = flag_reg;
        xdelta_next = xdelta_reg;
        result.ev = ps2mc_pkg::EV_STORED;
        result.apply = 1'b0;
        result.dx = {flag_reg[4], xdelta_reg};
        result.dy = {flag_reg[5], rx_byte};
        result.buttons = flag_reg[ps2mc_pkg::ButtonBits-1:0];
        case (pos_reg)
            POS_FLAG:
            begin
                if ((rx_byte & ps2mc_pkg::SyncMask) == 8'h00)
                begin
                    result.ev = ps2mc_pkg::EV_SYNC_DROP;
                end
                else
                begin
                    flag_next = rx_byte;
                    pos_next = POS_XDELTA;
                end
            end
            POS_XDELTA:
            begin
                xdelta_next = rx_byte;
                pos_next = POS_YDELTA;
            end
            default:
            begin
                // Third byte completes the packet.
                pos_next = POS_FLAG;
                if ((flag_reg & ps2mc_pkg::OverflowMask) != 8'h00)
                begin
                    result.ev = ps2mc_pkg::EV_OVF_DROP;
                end
                else
                begin
                    result.ev = ps2mc_pkg::EV_APPLIED;
                    result.apply = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_FLAG;
            flag_reg <= 8'h00;
            xdelta_reg <= 8'h00;
        end
        else if (step)
        begin
            pos_reg <= pos_next;
            flag_reg <= flag_next;
            xdelta_reg <= xdelta_next;
        end
    end

endmodule

// ----- sv/ps2mc_axis.sv -----
// One cursor axis: applies a signed delta and clamps to the screen limit.
module ps2mc_axis #(
    parameter int COORD_BITS = 13
) (
    input  logic [COORD_BITS-1:0]              pos,
    input  logic [ps2mc_pkg::DeltaBits-1:0]    delta,
    input  logic                               subtract,
    input  logic [ps2mc_pkg::SizeBits-1:0]     size,
    input  logic [ps2mc_pkg::SizeBits-1:0]     default_limit,
    output logic [COORD_BITS-1:0]              new_pos
);

    localparam int SumW = COORD_BITS + 2;
    localparam int LimW = (COORD_BITS > ps2mc_pkg::SizeBits) ? COORD_BITS
                                                              : ps2mc_pkg::SizeBits;

    logic signed [SumW-1:0] pos_ext;
    logic signed [SumW-1:0] delta_ext;
    logic signed [SumW-1:0] sum;
    logic [ps2mc_pkg::SizeBits-1:0] lim_raw;
    logic [LimW-1:0] lim_wide;
    logic [LimW-1:0] coord_max;
    logic [COORD_BITS-1:0] lim;

    always_comb
    begin
        pos_ext = $signed({2'b00, pos});
        delta_ext = $signed({{(SumW-ps2mc_pkg::DeltaBits){delta[ps2mc_pkg::DeltaBits-1]}},
                             delta});
        sum = subtract ? (pos_ext - delta_ext) : (pos_ext + delta_ext);

        lim_raw = (size == '0) ? default_limit : (size - 1'b1);
        lim_wide = LimW'(lim_raw);
        coord_max = LimW'({COORD_BITS{1'b1}});
        // A limit beyond the coordinate range saturates to the largest coordinate.
        lim = (lim_wide > coord_max) ? {COORD_BITS{1'b1}} : lim_wide[COORD_BITS-1:0];

        if (sum[SumW-1])
            new_pos = '0;
        else if (sum[COORD_BITS:0] > {1'b0, lim})
            new_pos = lim;
        else
            new_pos = sum[COORD_BITS-1:0];
    end

endmodule

// ----- sv/ps2_mouse_packet_cursor.sv -----
// PS/2 mouse packet decoder with a clamped cursor: top level.
//
// Takes one mouse byte per request and returns one result per byte carrying
// the cursor, buttons and an event code. Each byte is captured in an input
// register and decoded from there, and the result of the decode stage
// lands in the output register. A new byte is taken every cycle while the
// output side keeps up. Packet state and the cursor are
// updated in the decode stage, so consecutive bytes see each other's effect.
// Screen size registers should be written while no request is in flight.
module ps2_mouse_packet_cursor #(
    parameter int COORD_BITS = 13
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [ps2mc_pkg::SizeBits-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          rx_byte,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [COORD_BITS-1:0]               cursor_x,
    output logic [COORD_BITS-1:0]               cursor_y,
    output logic [ps2mc_pkg::ButtonBits-1:0]    button_bits,
    output logic [ps2mc_pkg::ButtonBits-1:0]    previous_buttons,
    output logic [1:0]                          event_code
);

    logic [ps2mc_pkg::SizeBits-1:0] width_reg;
    logic [ps2mc_pkg::SizeBits-1:0] height_reg;

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;

    logic out_valid_reg;
    logic [COORD_BITS-1:0] out_x_reg, out_y_reg;
    logic [ps2mc_pkg::ButtonBits-1:0] out_btn_reg, out_prev_reg;
    ps2mc_pkg::event_t out_ev_reg;

    logic [COORD_BITS-1:0] pos_x_reg, pos_y_reg;
    logic [ps2mc_pkg::ButtonBits-1:0] btn_now_reg, btn_before_reg;

    logic s2_adv;
    logic in_accept;
    logic step;
    ps2mc_pkg::step_t res;
    logic [COORD_BITS-1:0] new_x, new_y;
    logic [COORD_BITS-1:0] pos_x_next, pos_y_next;
    logic [ps2mc_pkg::ButtonBits-1:0] btn_now_next, btn_before_next;

    assign s2_adv = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !s2_adv;
    assign in_accept = in_valid && !in_stall;
    assign step = s1_valid_reg && s2_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= '0;
            height_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == ps2mc_pkg::REG_SCREEN_WIDTH)
                width_reg <= cfg_data;
            else if (cfg_index == ps2mc_pkg::REG_SCREEN_HEIGHT)
                height_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_accept)
            s1_valid_reg <= 1'b1;
        else if (s2_adv)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            s1_byte_reg <= rx_byte;
    end

    ps2mc_frame u_frame (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (s1_byte_reg),
        .result  (res)
    );

    ps2mc_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
        .pos           (pos_x_reg),
        .delta         (res.dx),
        .subtract      (1'b0),
        .size          (width_reg),
        .default_limit (ps2mc_pkg::DefaultLimitX),
        .new_pos       (new_x)
    );

    // PS/2 Y grows upward while screen rows grow downward.
    ps2mc_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
        .pos           (pos_y_reg),
        .delta         (res.dy),
        .subtract      (1'b1),
        .size          (height_reg),
        .default_limit (ps2mc_pkg::DefaultLimitY),
        .new_pos       (new_y)
    );

    always_comb
    begin
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        btn_now_next = btn_now_reg;
        btn_before_next = btn_before_reg;
        if (res.apply)
        begin
            pos_x_next = new_x;
            pos_y_next = new_y;
            btn_now_next = res.buttons;
            btn_before_next = btn_now_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= COORD_BITS'(ps2mc_pkg::ResetPosX);
            pos_y_reg <= COORD_BITS'(ps2mc_pkg::ResetPosY);
            btn_now_reg <= '0;
            btn_before_reg <= '0;
        end
        else if (step)
        begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            btn_now_reg <= btn_now_next;
            btn_before_reg <= btn_before_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s2_adv)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_x_reg <= pos_x_next;
            out_y_reg <= pos_y_next;
            out_btn_reg <= btn_now_next;
            out_prev_reg <= btn_before_next;
            out_ev_reg <= res.ev;
        end
    end

    assign out_valid = out_valid_reg;
    assign cursor_x = out_x_reg;
    assign cursor_y = out_y_reg;
    assign button_bits = out_btn_reg;
    assign previous_buttons = out_prev_reg;
    assign event_code = out_ev_reg;

endmodule

// ----- sv/ps2mc_checker.sv -----
// Port-level checker for the PS/2 mouse packet cursor, bound to the top level.
module ps2mc_checker #(
    parameter int COORD_BITS = 13
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic [COORD_BITS-1:0]               cursor_x,
    input logic [COORD_BITS-1:0]               cursor_y,
    input logic [ps2mc_pkg::ButtonBits-1:0]    button_bits,
    input logic [ps2mc_pkg::ButtonBits-1:0]    previous_buttons,
    input logic [1:0]                          event_code
);

    // A stalled result holds until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cursor_x) && $stable(cursor_y)
            && $stable(event_code))
    else $error("stalled result changed");

    // A byte that applies no packet leaves cursor and buttons as the prior result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) ##1 (out_valid && event_code != ps2mc_pkg::EV_APPLIED)
            |-> $stable(cursor_x) && $stable(cursor_y) && $stable(button_bits)
                && $stable(previous_buttons))
    else $error("cursor moved without an applied packet");

    // An applied packet moves the prior buttons into previous_buttons.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) ##1 (out_valid && event_code == ps2mc_pkg::EV_APPLIED)
            |-> previous_buttons == $past(button_bits))
    else $error("previous buttons not carried over");

endmodule

bind ps2_mouse_packet_cursor ps2mc_checker #(.COORD_BITS(COORD_BITS)) u_ps2mc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .cursor_x         (cursor_x),
    .cursor_y         (cursor_y),
    .button_bits      (button_bits),
    .previous_buttons (previous_buttons),
    .event_code       (event_code)
);

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the PS/2 mouse packet cursor block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CoordBits = 13;
    localparam int unsigned CoordMax = (1 << CoordBits) - 1;
    localparam int StuckLimit = 2000;
    localparam int ReportLimit = 10;

    typedef struct packed {
        logic [CoordBits-1:0]             x;
        logic [CoordBits-1:0]             y;
        logic [ps2mc_pkg::ButtonBits-1:0] buttons;
        logic [ps2mc_pkg::ButtonBits-1:0] prev_buttons;
        ps2mc_pkg::event_t                ev;
    } cursor_report_t;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             cfg_we;
    logic                             cfg_index;
    logic [ps2mc_pkg::SizeBits-1:0]   cfg_data;
    logic                             in_valid;
    logic                             in_stall;
    logic [7:0]                       rx_byte;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic [CoordBits-1:0]             cursor_x;
    logic [CoordBits-1:0]             cursor_y;
    logic [ps2mc_pkg::ButtonBits-1:0] button_bits;
    logic [ps2mc_pkg::ButtonBits-1:0] previous_buttons;
    logic [1:0]                       event_code;

    // Packet tracker and cursor, mirrored from the block's behavior.
    logic [1:0]                       byte_slot = 2'd0;
    logic [7:0]                       held_flags = 8'h00;
    logic [7:0]                       held_dx = 8'h00;
    int unsigned                      track_x = ps2mc_pkg::ResetPosX;
    int unsigned                      track_y = ps2mc_pkg::ResetPosY;
    logic [ps2mc_pkg::ButtonBits-1:0] track_buttons = '0;
    logic [ps2mc_pkg::ButtonBits-1:0] track_prev = '0;
    logic [ps2mc_pkg::SizeBits-1:0]   width_setting = '0;
    logic [ps2mc_pkg::SizeBits-1:0]   height_setting = '0;

    cursor_report_t         pending_cursor[$];
    int                     mismatches = 0;
    int                     stuck_cycles = 0;
    int unsigned            send_idle_pct = 0;
    int unsigned            stall_pct = 0;

    ps2_mouse_packet_cursor #(
        .COORD_BITS(CoordBits)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .cursor_x(cursor_x),
        .cursor_y(cursor_y),
        .button_bits(button_bits),
        .previous_buttons(previous_buttons),
        .event_code(event_code)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned axis_max(input logic [ps2mc_pkg::SizeBits-1:0] size,
                                             input int unsigned fallback);
        int unsigned lim;
        lim = (size != '0) ? int'(size) - 1 : fallback;
        return (lim > CoordMax) ? CoordMax : lim;
    endfunction

    function automatic int unsigned clamp_axis(input int pos, input int unsigned lim);
        if (pos < 0)
            return 0;
        if (pos > int'(lim))
            return lim;
        return pos;
    endfunction

    function automatic cursor_report_t decode_mouse_byte(input logic [7:0] b);
        cursor_report_t r;
        int dx;
        int dy;
        r.ev = ps2mc_pkg::EV_STORED;
        if (byte_slot == 2'd0)
        begin
            if ((b & ps2mc_pkg::SyncMask) == 8'h00)
                r.ev = ps2mc_pkg::EV_SYNC_DROP;
            else
            begin
                held_flags = b;
                byte_slot = 2'd1;
            end
        end
        else if (byte_slot == 2'd1)
        begin
            held_dx = b;
            byte_slot = 2'd2;
        end
        else
        begin
            byte_slot = 2'd0;
            if ((held_flags & ps2mc_pkg::OverflowMask) != 8'h00)
                r.ev = ps2mc_pkg::EV_OVF_DROP;
            else
            begin
                // Sign bits 4 and 5 of the flag byte extend the deltas to nine bits.
                dx = $signed({held_flags[4], held_dx});
                dy = $signed({held_flags[5], b});
                track_x = clamp_axis(int'(track_x) + dx,
                                     axis_max(width_setting, ps2mc_pkg::DefaultLimitX));
                track_y = clamp_axis(int'(track_y) - dy,
                                     axis_max(height_setting, ps2mc_pkg::DefaultLimitY));
                track_prev = track_buttons;
                track_buttons = held_flags[2:0];
                r.ev = ps2mc_pkg::EV_APPLIED;
            end
        end
        r.x = track_x[CoordBits-1:0];
        r.y = track_y[CoordBits-1:0];
        r.buttons = track_buttons;
        r.prev_buttons = track_prev;
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        pending_cursor.push_back(decode_mouse_byte(b));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_cursor.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_screen(input logic [ps2mc_pkg::SizeBits-1:0] w,
                              input logic [ps2mc_pkg::SizeBits-1:0] h);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_index <= ps2mc_pkg::REG_SCREEN_WIDTH;
        cfg_data <= w;
        @(negedge clk);
        cfg_index <= ps2mc_pkg::REG_SCREEN_HEIGHT;
        cfg_data <= h;
        @(negedge clk);
        cfg_we <= 1'b0;
        width_setting = w;
        height_setting = h;
        @(negedge clk);
    endtask

    task automatic report_mismatch(input string what, input cursor_report_t want,
                                   input cursor_report_t got);
        mismatches++;
        if (mismatches <= ReportLimit)
            $display("%0t: %s: expected x=%0d y=%0d buttons=%0d previous=%0d event=%0d,",
                     $time, what, want.x, want.y, want.buttons, want.prev_buttons, want.ev,
                     " got x=%0d y=%0d buttons=%0d previous=%0d event=%0d",
                     got.x, got.y, got.buttons, got.prev_buttons, got.ev);
    endtask

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        cursor_report_t want;
        cursor_report_t got;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            got.x = cursor_x;
            got.y = cursor_y;
            got.buttons = button_bits;
            got.prev_buttons = previous_buttons;
            got.ev = ps2mc_pkg::event_t'(event_code);
            if (pending_cursor.size() == 0)
                report_mismatch("cursor report with no request outstanding", '0, got);
            else
            begin
                want = pending_cursor.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.buttons !== want.buttons ||
                    got.prev_buttons !== want.prev_buttons || got.ev !== want.ev)
                    report_mismatch("cursor report mismatch", want, got);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (in_valid && in_stall === 1'b0) ||
            (out_valid === 1'b1 && !out_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin
        do
            @(negedge clk);
        while (stuck_cycles < StuckLimit);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Sync drops, delta extremes in both directions, overflow drops and clamping
    // on the default screen.
    task automatic test_sync_and_extremes();
        logic [7:0] seq [] = '{8'h00, 8'hF7,
                               8'h08, 8'h00, 8'h00,
                               8'h3F, 8'h00, 8'h00,
                               8'h3B, 8'h00, 8'h00,
                               8'h48, 8'h12, 8'h34,
                               8'hFF, 8'hFF, 8'hFF,
                               8'h0C, 8'hFF, 8'hFF,
                               8'h0D, 8'hFF, 8'hFF,
                               8'h08, 8'hFF, 8'hFF};
        send_idle_pct = 0;
        stall_pct = 0;
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    // Largest screen, limits beyond the coordinate range, a shrunk screen that
    // only takes effect on the next applied packet, and a one-pixel screen.
    task automatic test_screen_limits();
        send_idle_pct = 23;
        stall_pct = 23;
        set_screen(14'd8192, 14'd8192);
        repeat (33)
        begin
            send_byte(8'h28);
            send_byte(8'hFF);
            send_byte(8'h00);
        end
        set_screen(14'd16383, 14'd16383);
        send_byte(8'h28);
        send_byte(8'hFF);
        send_byte(8'h00);
        set_screen(14'd100, 14'd50);
        send_byte(8'h00);
        send_byte(8'h08);
        send_byte(8'h00);
        send_byte(8'h00);
        set_screen(14'd1, 14'd1);
        send_byte(8'h0F);
        send_byte(8'h10);
        send_byte(8'hF0);
    endtask

    // Mostly well-formed packets with random content, plus stray bytes.
    task automatic test_random_traffic(input int unsigned idle, input int unsigned stall,
                                       input logic [ps2mc_pkg::SizeBits-1:0] w,
                                       input logic [ps2mc_pkg::SizeBits-1:0] h,
                                       input int count);
        int sent;
        logic [1:0] ovf;
        set_screen(w, h);
        send_idle_pct = idle;
        stall_pct = stall;
        sent = 0;
        while (sent < count)
        begin
            // Finish a packet that a stray byte opened so the next one lines up.
            while (byte_slot != 2'd0)
            begin
                send_byte(8'($urandom_range(255)));
                sent++;
            end
            if ($urandom_range(99) < 12)
            begin
                send_byte(8'($urandom_range(255)));
                sent++;
            end
            else
            begin
                ovf = ($urandom_range(9) == 0) ? 2'($urandom_range(3, 1)) : 2'b00;
                send_byte({ovf, 2'($urandom_range(3)), 1'b1, 3'($urandom_range(7))});
                send_byte(8'($urandom_range(255)));
                send_byte(8'($urandom_range(255)));
                sent += 3;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        rx_byte = 8'h00;
        cfg_we = 1'b0;
        cfg_index = ps2mc_pkg::REG_SCREEN_WIDTH;
        cfg_data = '0;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_sync_and_extremes();
        test_screen_limits();
        test_random_traffic(0, 0, 14'd0, 14'd0, 190);
        test_random_traffic(45, 0, 14'd640, 14'd480, 190);
        test_random_traffic(0, 45, 14'd16383, 14'd8192, 190);
        test_random_traffic(23, 23, 14'd37, 14'd3000, 190);
        wait_drained();
        repeat (8)
            @(negedge clk);
        if (mismatches == 0 && pending_cursor.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- files.f -----
sv/ps2mc_pkg.sv
sv/ps2mc_frame.sv
sv/ps2mc_axis.sv
sv/ps2_mouse_packet_cursor.sv
sv/ps2mc_checker.sv
tb/sv/tb.sv
